@@ hdl/sct_pkg.sv @@
// ----------------------------------------------------------------------------
// sct_pkg
// Shared widths, codes and types of the crossover position tracker.
// ----------------------------------------------------------------------------
package sct_pkg;

	localparam int PRICE_W  = 32;
	localparam int TIME_W   = 48;
	localparam int PROFIT_W = 33;
	localparam int TOTAL_W  = 48;
	localparam int FRAC_W   = 16;
	localparam int HOLD_W   = 32;
	localparam int COUNT_W  = 32;
	localparam int EVENT_W  = 3;
	localparam int POS_W    = 2;
	localparam int REL_W    = 2;

	localparam int IN_TDATA_W  = 144;
	localparam int OUT_TDATA_W = 152;
	localparam int OUT_TUSER_W = EVENT_W;
	localparam int OUT_PAD_W   = OUT_TDATA_W - (PRICE_W + PROFIT_W + TOTAL_W + POS_W + COUNT_W);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam int LONG_WIN_DEF  = 32;
	localparam int SHORT_WIN_DEF = 8;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [EVENT_W-1:0] EV_NONE        = 3'd0;
	localparam logic [EVENT_W-1:0] EV_ENTER_LONG  = 3'd1;
	localparam logic [EVENT_W-1:0] EV_ENTER_SHORT = 3'd2;
	localparam logic [EVENT_W-1:0] EV_EXIT_LONG   = 3'd3;
	localparam logic [EVENT_W-1:0] EV_EXIT_SHORT  = 3'd4;

	localparam logic [POS_W-1:0] POS_FLAT  = 2'd0;
	localparam logic [POS_W-1:0] POS_LONG  = 2'd1;
	localparam logic [POS_W-1:0] POS_SHORT = 2'd2;

	localparam logic [REL_W-1:0] REL_LESS    = 2'd0;
	localparam logic [REL_W-1:0] REL_EQUAL   = 2'd1;
	localparam logic [REL_W-1:0] REL_GREATER = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_STOP_LOSS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRAIL_KEEP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TAKE_PROFIT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_HOLD    = 2'd3;

	localparam logic [FRAC_W-1:0] STOP_LOSS_RST   = 16'd655;
	localparam logic [FRAC_W-1:0] TRAIL_KEEP_RST  = 16'd58982;
	localparam logic [FRAC_W-1:0] TAKE_PROFIT_RST = 16'd131;
	localparam logic [HOLD_W-1:0] MIN_HOLD_RST    = 32'd10;

	localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
	localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

	typedef struct packed {
		logic [REL_W-1:0]   rel;
		logic               full;
		logic [PRICE_W-1:0] bid;
		logic [PRICE_W-1:0] ask;
		logic [TIME_W-1:0]  tick_time;
	} sct_item_t;

	typedef struct packed {
		logic [FRAC_W-1:0] stop_loss_fraction;
		logic [FRAC_W-1:0] trail_keep_fraction;
		logic [FRAC_W-1:0] take_profit_fraction;
		logic [HOLD_W-1:0] min_hold_time;
	} sct_cfg_t;

endpackage

@@ hdl/sct_front.sv @@
// ----------------------------------------------------------------------------
// sct_front
// Price window with running long and short sums, and the trend comparison.
// ----------------------------------------------------------------------------
module sct_front #(
	parameter int LONG_WIN  = sct_pkg::LONG_WIN_DEF,
	parameter int SHORT_WIN = sct_pkg::SHORT_WIN_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [sct_pkg::IN_TDATA_W-1:0] in_data,
	output logic                           push_valid,
	input  logic                           push_ready,
	output sct_pkg::sct_item_t             push_item
);
	import sct_pkg::*;

	localparam int SHORT_N = (SHORT_WIN > LONG_WIN) ? LONG_WIN : SHORT_WIN;
	localparam int AW      = $clog2(LONG_WIN);
	localparam int CW      = $clog2(LONG_WIN + 1);
	localparam int LS_W    = PRICE_W + $clog2(LONG_WIN + 1);
	localparam int SS_W    = PRICE_W + $clog2(SHORT_N + 1);
	localparam int CMP_W   = LS_W + SS_W;

	logic [PRICE_W-1:0] win_mem [LONG_WIN];
	logic [PRICE_W-1:0] rd_long_q;
	logic [PRICE_W-1:0] rd_short_q;
	logic [AW-1:0]      wslot_q;
	logic [CW-1:0]      fill_q;
	logic [LS_W-1:0]    long_sum_q;
	logic [SS_W-1:0]    short_sum_q;

	logic               valid_s1;
	logic               full_s1;
	logic [PRICE_W-1:0] bid_s1;
	logic [PRICE_W-1:0] ask_s1;
	logic [TIME_W-1:0]  time_s1;

	logic               accept;
	logic [PRICE_W-1:0] avg;
	logic [AW-1:0]      wslot_nx;
	logic [AW-1:0]      short_addr;
	logic [PRICE_W-1:0] long_drop;
	logic [PRICE_W-1:0] short_drop;
	logic [LS_W-1:0]    long_nx;
	logic [SS_W-1:0]    short_nx;
	logic [CW-1:0]      fill_nx;
	logic [CMP_W-1:0]   lhs;
	logic [CMP_W-1:0]   rhs;

	assign in_ready   = !valid_s1 || push_ready;
	assign accept     = in_valid && in_ready;
	assign push_valid = valid_s1;
	assign avg        = in_data[PRICE_W-1:0];

	always_comb begin
		wslot_nx = (wslot_q == AW'(LONG_WIN - 1)) ? '0 : wslot_q + 1'b1;
		if (wslot_nx >= AW'(SHORT_N)) begin
			short_addr = wslot_nx - AW'(SHORT_N);
		end else begin
			short_addr = wslot_nx + AW'(LONG_WIN - SHORT_N);
		end
		long_drop  = (fill_q >= CW'(LONG_WIN)) ? rd_long_q : '0;
		short_drop = (fill_q >= CW'(SHORT_N)) ? rd_short_q : '0;
		long_nx    = long_sum_q + LS_W'(avg) - LS_W'(long_drop);
		if (SHORT_N == 1) begin
			short_nx = SS_W'(avg);
		end else begin
			short_nx = short_sum_q + SS_W'(avg) - SS_W'(short_drop);
		end
		fill_nx = (fill_q == CW'(LONG_WIN)) ? fill_q : fill_q + 1'b1;
	end

	// The window is read one beat ahead: the slots that the next beat drops.
	always_ff @(posedge clk) begin
		if (accept) begin
			win_mem[wslot_q] <= avg;
			rd_long_q        <= win_mem[wslot_nx];
			rd_short_q       <= win_mem[short_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wslot_q     <= '0;
			fill_q      <= '0;
			long_sum_q  <= '0;
			short_sum_q <= '0;
			valid_s1    <= 1'b0;
		end else begin
			if (accept) begin
				wslot_q     <= wslot_nx;
				fill_q      <= fill_nx;
				long_sum_q  <= long_nx;
				short_sum_q <= short_nx;
				valid_s1    <= 1'b1;
			end else if (push_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			full_s1 <= (fill_nx == CW'(LONG_WIN));
			bid_s1  <= in_data[2*PRICE_W-1:PRICE_W];
			ask_s1  <= in_data[3*PRICE_W-1:2*PRICE_W];
			time_s1 <= in_data[3*PRICE_W+TIME_W-1:3*PRICE_W];
		end
	end

	always_comb begin
		lhs = CMP_W'(short_sum_q) * CMP_W'(LONG_WIN);
		rhs = CMP_W'(long_sum_q) * CMP_W'(SHORT_N);
		push_item.full      = full_s1;
		push_item.bid       = bid_s1;
		push_item.ask       = ask_s1;
		push_item.tick_time = time_s1;
		if (lhs < rhs) begin
			push_item.rel = REL_LESS;
		end else if (lhs > rhs) begin
			push_item.rel = REL_GREATER;
		end else begin
			push_item.rel = REL_EQUAL;
		end
	end

endmodule

@@ hdl/sct_queue.sv @@
// ----------------------------------------------------------------------------
// sct_queue
// Short queue of classified ticks between the window and the position logic.
// ----------------------------------------------------------------------------
module sct_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  sct_pkg::sct_item_t push_item,
	output logic               pop_valid,
	input  logic               pop_ready,
	output sct_pkg::sct_item_t pop_item
);
	import sct_pkg::*;

	sct_item_t         entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/sct_back.sv @@
// ----------------------------------------------------------------------------
// sct_back
// Position logic: entries, exits, profit totals and the result register.
// ----------------------------------------------------------------------------
module sct_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sct_pkg::sct_cfg_t                   cfg,
	input  logic                                pop_valid,
	output logic                                pop_ready,
	input  sct_pkg::sct_item_t                  pop_item,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [sct_pkg::EVENT_W-1:0]         out_event,
	output logic [sct_pkg::PRICE_W-1:0]         out_price,
	output logic signed [sct_pkg::PROFIT_W-1:0] out_profit,
	output logic signed [sct_pkg::TOTAL_W-1:0]  out_total,
	output logic [sct_pkg::POS_W-1:0]           out_pos,
	output logic [sct_pkg::COUNT_W-1:0]         out_closed
);
	import sct_pkg::*;

	localparam int PROD_W = PRICE_W + FRAC_W;

	logic [POS_W-1:0]           pos_q;
	logic [REL_W-1:0]           prev_rel_q;
	logic [PRICE_W-1:0]         open_price_q;
	logic [TIME_W-1:0]          open_time_q;
	logic [PRICE_W-1:0]         loss_q;
	logic [PRICE_W-1:0]         target_q;
	logic [PRICE_W-1:0]         best_q;
	logic signed [TOTAL_W-1:0]  total_q;
	logic [COUNT_W-1:0]         closed_q;
	logic                       out_valid_q;

	logic                       take;
	logic                       is_long;
	logic                       enter_long;
	logic                       enter_short;
	logic                       held_pos;
	logic [PRICE_W-1:0]         open_px;
	logic [PRICE_W+FRAC_W-1:0]  loss_prod;
	logic [PRICE_W+FRAC_W-1:0]  target_prod;
	logic [PRICE_W+FRAC_W-1:0]  trail_prod;
	logic signed [PROFIT_W-1:0] profit;
	logic signed [PROFIT_W:0]   profit_wide;
	logic signed [PROFIT_W:0]   neg_loss;
	logic [TIME_W-1:0]          elapsed;
	logic                       held_long_enough;
	logic                       reversal;
	logic                       trailing;
	logic                       hard_stop;
	logic                       target_hit;
	logic                       exit_now;
	logic                       new_best;
	logic signed [TOTAL_W:0]    sum;
	logic signed [TOTAL_W-1:0]  total_nx;
	logic [COUNT_W-1:0]         closed_nx;
	logic [EVENT_W-1:0]         event_nx;
	logic [PRICE_W-1:0]         price_nx;
	logic signed [PROFIT_W-1:0] trade_nx;
	logic [POS_W-1:0]           pos_nx;

	assign pop_ready = !out_valid_q || out_ready;
	assign take      = pop_valid && pop_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		is_long     = (pos_q == POS_LONG);
		held_pos    = pop_item.full && (pos_q != POS_FLAT);
		enter_long  = pop_item.full && (pos_q == POS_FLAT) && (prev_rel_q != REL_GREATER) &&
			(pop_item.rel == REL_GREATER);
		enter_short = pop_item.full && (pos_q == POS_FLAT) && !enter_long &&
			(prev_rel_q != REL_LESS) && (pop_item.rel == REL_LESS);
		open_px     = enter_long ? pop_item.ask : pop_item.bid;
		loss_prod   = PROD_W'(open_px) * PROD_W'(cfg.stop_loss_fraction);
		target_prod = PROD_W'(open_px) * PROD_W'(cfg.take_profit_fraction);
		trail_prod  = PROD_W'(best_q) * PROD_W'(cfg.trail_keep_fraction);

		if (is_long) begin
			profit = $signed({1'b0, pop_item.bid}) - $signed({1'b0, open_price_q});
		end else begin
			profit = $signed({1'b0, open_price_q}) - $signed({1'b0, pop_item.ask});
		end
		profit_wide = {profit[PROFIT_W-1], profit};
		neg_loss    = -$signed({2'b00, loss_q});

		elapsed          = pop_item.tick_time - open_time_q;
		held_long_enough = (pop_item.tick_time >= open_time_q) &&
			(elapsed > TIME_W'(cfg.min_hold_time));
		reversal   = is_long ? (pop_item.rel == REL_LESS) : (pop_item.rel == REL_GREATER);
		// A new best profit can never trigger the trailing exit on its own tick,
		// so the stored best serves for the comparison.
		trailing   = !profit[PROFIT_W-1] && (profit != '0) &&
			({profit[PRICE_W-1:0], {FRAC_W{1'b0}}} < trail_prod);
		hard_stop  = profit_wide < neg_loss;
		target_hit = profit_wide > $signed({2'b00, target_q});
		exit_now   = held_pos &&
			(((reversal || trailing) && held_long_enough) || hard_stop || target_hit);
		new_best   = held_pos && (profit > $signed({1'b0, best_q}));

		sum = $signed({total_q[TOTAL_W-1], total_q}) +
			$signed({{(TOTAL_W + 1 - PROFIT_W){profit[PROFIT_W-1]}}, profit});
		if (sum[TOTAL_W] != sum[TOTAL_W-1]) begin
			total_nx = sum[TOTAL_W] ? TOTAL_MIN : TOTAL_MAX;
		end else begin
			total_nx = sum[TOTAL_W-1:0];
		end
		closed_nx = (closed_q == {COUNT_W{1'b1}}) ? closed_q : closed_q + 1'b1;

		event_nx = EV_NONE;
		price_nx = '0;
		trade_nx = '0;
		pos_nx   = pos_q;
		if (enter_long) begin
			event_nx = EV_ENTER_LONG;
			price_nx = open_px;
			pos_nx   = POS_LONG;
		end else if (enter_short) begin
			event_nx = EV_ENTER_SHORT;
			price_nx = open_px;
			pos_nx   = POS_SHORT;
		end else if (exit_now) begin
			event_nx = is_long ? EV_EXIT_LONG : EV_EXIT_SHORT;
			price_nx = is_long ? pop_item.bid : pop_item.ask;
			trade_nx = profit;
			pos_nx   = POS_FLAT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= POS_FLAT;
			prev_rel_q   <= REL_EQUAL;
			open_price_q <= '0;
			open_time_q  <= '0;
			loss_q       <= '0;
			target_q     <= '0;
			best_q       <= '0;
			total_q      <= '0;
			closed_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
				pos_q       <= pos_nx;
				if (pop_item.full) begin
					prev_rel_q <= pop_item.rel;
				end
				if (enter_long || enter_short) begin
					open_price_q <= open_px;
					open_time_q  <= pop_item.tick_time;
					loss_q       <= loss_prod[PRICE_W+FRAC_W-1:FRAC_W];
					target_q     <= target_prod[PRICE_W+FRAC_W-1:FRAC_W];
					best_q       <= '0;
				end else if (new_best) begin
					best_q <= profit[PRICE_W-1:0];
				end
				if (exit_now) begin
					total_q  <= total_nx;
					closed_q <= closed_nx;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_event  <= event_nx;
			out_price  <= price_nx;
			out_profit <= trade_nx;
			out_total  <= exit_now ? total_nx : total_q;
			out_pos    <= pos_nx;
			out_closed <= exit_now ? closed_nx : closed_q;
		end
	end

endmodule

@@ hdl/sma_crossover_position_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// sma_crossover_position_tracker_unit
// Moving-average crossover position tracker: one result beat per tick beat.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                    | payload
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | tick: prices and timestamp
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | event, trade and totals
//  cfg       | in        | cfg_write                    | cfg_index, cfg_data
//
// A tick beat is taken every cycle when results drain; its result beat goes through
// the window stage, the queue and the result register, in that order, before it is presented.
// The rate is set by the single window write per cycle and the registered
// position update, which reads its own state back on the next beat.
// Reset clears counters, sums and position at once; there is no clearing pass.
// A stalled result holds in the output register while the queue keeps
// absorbing ticks; s_axis_tready falls only when the queue is full.
// ----------------------------------------------------------------------------
module sma_crossover_position_tracker_unit #(
	parameter int LONG_WIN  = sct_pkg::LONG_WIN_DEF,
	parameter int SHORT_WIN = sct_pkg::SHORT_WIN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// avg_price, bid_price, ask_price, tick_time
	input  logic [sct_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// trade_price, trade_profit, total_profit, position, trades_closed, zero fill
	output logic [sct_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// event_res
	output logic [sct_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
	input  logic                            cfg_write,
	input  logic [sct_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sct_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import sct_pkg::*;

	sct_cfg_t                   cfg_q;
	sct_item_t                  push_item;
	sct_item_t                  pop_item;
	logic                       push_valid;
	logic                       push_ready;
	logic                       pop_valid;
	logic                       pop_ready;
	logic [EVENT_W-1:0]         out_event;
	logic [PRICE_W-1:0]         out_price;
	logic signed [PROFIT_W-1:0] out_profit;
	logic signed [TOTAL_W-1:0]  out_total;
	logic [POS_W-1:0]           out_pos;
	logic [COUNT_W-1:0]         out_closed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stop_loss_fraction   <= STOP_LOSS_RST;
			cfg_q.trail_keep_fraction  <= TRAIL_KEEP_RST;
			cfg_q.take_profit_fraction <= TAKE_PROFIT_RST;
			cfg_q.min_hold_time        <= MIN_HOLD_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_STOP_LOSS: begin
					cfg_q.stop_loss_fraction <= cfg_data[FRAC_W-1:0];
				end
				CFG_TRAIL_KEEP: begin
					cfg_q.trail_keep_fraction <= cfg_data[FRAC_W-1:0];
				end
				CFG_TAKE_PROFIT: begin
					cfg_q.take_profit_fraction <= cfg_data[FRAC_W-1:0];
				end
				CFG_MIN_HOLD: begin
					cfg_q.min_hold_time <= cfg_data[HOLD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	sct_front #(
		.LONG_WIN  (LONG_WIN),
		.SHORT_WIN (SHORT_WIN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_data    (s_axis_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	sct_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	sct_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_event  (out_event),
		.out_price  (out_price),
		.out_profit (out_profit),
		.out_total  (out_total),
		.out_pos    (out_pos),
		.out_closed (out_closed)
	);

	assign m_axis_tuser = out_event;
	assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_closed, out_pos, out_total, out_profit,
		out_price};

	// An exit beat always leaves the position flat.
	a_exit_flat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (out_event == EV_EXIT_LONG || out_event == EV_EXIT_SHORT)
		|-> out_pos == POS_FLAT)
		else $error("exit beat with an open position");

	// A beat without an event carries no trade.
	a_none_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_event == EV_NONE |-> out_price == '0 && out_profit == '0)
		else $error("trade fields set on a beat without an event");

	// The count of closed trades never goes backwards between result beats.
	a_closed_mono: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && $past(m_axis_tvalid) |-> out_closed >= $past(out_closed))
		else $error("closed trade count decreased");

endmodule
